/* rtl/scf_pkg.sv */
// Shared types, constants and helpers for the scroll follow controller.
`timescale 1ns / 1ps

package scf_pkg;

   // Shared multiplier operand and product widths
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 17;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Register file address width (five 32-bit registers at 4-byte spacing)
   localparam int CSR_ADDR_W = 5;

   // Reset values
   localparam logic signed [31:0] POS_RESET          = -32'sd19200;
   localparam logic [11:0]        WINDOW_WIDTH_RESET = 12'd1280;
   localparam logic signed [20:0] LEVEL_LEFT_RESET   = 21'sd0;
   localparam logic [20:0]        LEVEL_WIDTH_RESET  = 21'd1280;
   localparam logic [15:0]        ACCEL_RATE_RESET   = 16'd1000;
   localparam logic [15:0]        SPEED_LIMIT_RESET  = 16'd500;

   // floor(W * 1024 / 5) == (W * FIFTH_RECIP) >> FIFTH_SHIFT, exact for 12-bit W
   localparam logic signed [MUL_A_W-1:0] FIFTH_RECIP = 34'sd3355444;
   localparam int                        FIFTH_SHIFT = 14;

   // Sequencer steps
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROD,
      ST_D40,
      ST_MARGIN,
      ST_ZONE,
      ST_SPEED1,
      ST_SPEED2,
      ST_CLAMP,
      ST_STEP,
      ST_INTEG,
      ST_FOLLOW,
      ST_LEVEL
   } state_type;

   // Register indexes (byte address = 4 * index)
   typedef enum logic [2:0] {
      REG_WINDOW_WIDTH = 3'd0,
      REG_LEVEL_LEFT   = 3'd1,
      REG_LEVEL_WIDTH  = 3'd2,
      REG_ACCEL_RATE   = 3'd3,
      REG_SPEED_LIMIT  = 3'd4
   } reg_index_type;

   // Operand pair for the shared multiplier
   typedef struct packed {
      logic signed [MUL_A_W-1:0] a;
      logic signed [MUL_B_W-1:0] b;
   } mul_req_type;

   // Saturate a 33-bit signed value to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [32:0] x);
      logic signed [31:0] r;
      if (x[32] != x[31]) begin
         r = x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

/* rtl/scf_mul.sv */
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module scf_mul import scf_pkg::*; (
   input  logic                      clock,
   input  mul_req_type               mul_req,
   output logic signed [MUL_P_W-1:0] mul_p
);

   logic signed [MUL_P_W-1:0] a_x;
   logic signed [MUL_P_W-1:0] b_x;
   logic signed [MUL_P_W-1:0] mul_p_in;
   logic signed [MUL_P_W-1:0] mul_p_ff;

   // Sign-extend both operands to the product width, then multiply
   assign a_x      = {{(MUL_P_W - MUL_A_W){mul_req.a[MUL_A_W-1]}}, mul_req.a};
   assign b_x      = {{(MUL_P_W - MUL_B_W){mul_req.b[MUL_B_W-1]}}, mul_req.b};
   assign mul_p_in = a_x * b_x;

   // Register the product
   always_ff @(posedge clock) begin
      mul_p_ff <= mul_p_in;
   end

   assign mul_p = mul_p_ff;

endmodule

/* rtl/scroll_follow_controller_core.sv */
// Top level of the scroll follow controller: sequencer, datapath and register file.
//
//   Channel   Dir   Handshake            Payload
//   req_*     in    tvalid/tready        frame_time, target_left, target_velocity
//   rsp_*     out   tvalid/tready        scroll_x
//   csr_*     in    APB write/read       window_width, level_left, level_width,
//                                        accel_rate, speed_limit
//
// A result is valid once its transfer has run through every sequencer step, using the
// single shared multiplier and the speed and position updates; the next frame can
// transfer once the sequencer has returned to idle.
// A new frame is taken only in the idle step; a held result in the output register
// does not block the next transfer, but the last step waits while it is still held.
// Reset (synchronous) returns the sequencer to idle, clears the output valid,
// sets the position to -75 pixels, the speed to zero and the registers to defaults.
`timescale 1ns / 1ps

module scroll_follow_controller_core import scf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // Input frames
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [63:0]           req_tdata,   // [15:0] frame_time, [47:16] target_left,
                                              // [63:48] target_velocity
   // Results
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,   // [31:0] scroll_x
   // Register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   // Sequencer and handshake
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;

   // Registers
   logic [11:0]        window_width_ff, window_width_in;
   logic signed [20:0] level_left_ff, level_left_in;
   logic [20:0]        level_width_ff, level_width_in;
   logic [15:0]        accel_rate_ff, accel_rate_in;
   logic [15:0]        speed_limit_ff, speed_limit_in;

   // Architectural state
   logic signed [31:0] pos_ff, pos_in;
   logic signed [23:0] speed_ff, speed_in;

   // Per-frame working registers
   logic [15:0]        dt_ff, dt_in;
   logic signed [31:0] tgt_ff, tgt_in;
   logic               vel_neg_ff, vel_neg_in;
   logic               vel_pos_ff, vel_pos_in;
   logic signed [32:0] diff_ff, diff_in;
   logic [31:0]        prod_ff, prod_in;
   logic signed [38:0] d40_ff, d40_in;
   logic [19:0]        lo_m_ff, lo_m_in;
   logic               le9_ff, le9_in;
   logic               le18_ff, le18_in;
   logic               ge22_ff, ge22_in;
   logic               ge31_ff, ge31_in;
   logic signed [25:0] spd_ff, spd_in;

   // Shared multiplier
   mul_req_type               mul_req;
   logic signed [MUL_P_W-1:0] mul_p;

   // Combinational helpers
   logic               req_xfer;
   logic               cfg_wr;
   reg_index_type      cfg_idx;
   logic [15:0]        req_frame_time;
   logic signed [31:0] req_target_left;
   logic signed [15:0] req_target_velocity;
   logic signed [25:0] lim_s;
   logic signed [25:0] full_s;
   logic signed [25:0] half_s;
   logic signed [25:0] spd_cur;
   logic signed [25:0] add1;
   logic signed [38:0] w8_x;
   logic signed [38:0] t9, t18, t22, t31;
   logic signed [24:0] inc;
   logic signed [32:0] pos_x;
   logic signed [32:0] lo33, hi33;
   logic signed [22:0] right_sum;
   logic signed [32:0] left33, right33, w8_33, back33, end33;
   logic               slot_free;

   scf_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .mul_p   (mul_p)
   );

   // Unpack ports
   assign req_frame_time      = req_tdata[15:0];
   assign req_target_left     = req_tdata[47:16];
   assign req_target_velocity = req_tdata[63:48];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_idx    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   // Read back registers
   always_comb begin
      case (cfg_idx)
         REG_WINDOW_WIDTH: csr_prdata = {20'd0, window_width_ff};
         REG_LEVEL_LEFT:   csr_prdata = {{11{level_left_ff[20]}}, level_left_ff};
         REG_LEVEL_WIDTH:  csr_prdata = {11'd0, level_width_ff};
         REG_ACCEL_RATE:   csr_prdata = {16'd0, accel_rate_ff};
         REG_SPEED_LIMIT:  csr_prdata = {16'd0, speed_limit_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   // Speed operands (Q17.7)
   assign lim_s   = {3'd0, speed_limit_ff, 7'd0};
   assign full_s  = {3'd0, prod_ff[31:9]};
   assign half_s  = {4'd0, prod_ff[31:10]};
   assign spd_cur = {{2{speed_ff[23]}}, speed_ff};

   // Zone thresholds k * W * 256
   assign w8_x = {19'd0, window_width_ff, 8'd0};
   assign t9   = (w8_x <<< 3) + w8_x;
   assign t18  = (w8_x <<< 4) + (w8_x <<< 1);
   assign t22  = (w8_x <<< 4) + (w8_x <<< 2) + (w8_x <<< 1);
   assign t31  = (w8_x <<< 5) - w8_x;

   // Position increment: floor(speed * dt / 2^15)
   assign inc   = mul_p[39:15];
   assign pos_x = {pos_ff[31], pos_ff};

   // Follow margins: 0.8 W and 0.2 W behind the target
   assign lo33 = {tgt_ff[31], tgt_ff} - {13'd0, lo_m_ff};
   assign hi33 = {tgt_ff[31], tgt_ff} - {15'd0, lo_m_ff[19:2]};

   // Level bounds
   assign right_sum = {{2{level_left_ff[20]}}, level_left_ff} + {2'd0, level_width_ff};
   assign left33    = {{4{level_left_ff[20]}}, level_left_ff, 8'd0};
   assign right33   = {{2{right_sum[22]}}, right_sum, 8'd0};
   assign w8_33     = {13'd0, window_width_ff, 8'd0};
   assign back33    = right33 - w8_33;
   assign end33     = pos_x + w8_33;

   // Pick the first speed adjustment from zone, velocity sign and current speed
   always_comb begin
      add1 = 26'sd0;
      if (le9_ff) begin
         add1 = -full_s;
      end else if (le18_ff) begin
         if (vel_neg_ff && (spd_cur > -lim_s)) begin
            add1 = -full_s;
         end else if (!vel_neg_ff && (spd_cur < 26'sd0)) begin
            add1 = half_s;
         end
      end else if (ge31_ff) begin
         add1 = full_s;
      end else if (ge22_ff) begin
         if (vel_pos_ff && (spd_cur < lim_s)) begin
            add1 = full_s;
         end else if (!vel_pos_ff && (spd_cur > 26'sd0)) begin
            add1 = -half_s;
         end
      end
   end

   // Sequencer: next state, multiplier operands, datapath and register writes
   always_comb begin
      state_in        = state_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_data_in     = rsp_data_ff;
      window_width_in = window_width_ff;
      level_left_in   = level_left_ff;
      level_width_in  = level_width_ff;
      accel_rate_in   = accel_rate_ff;
      speed_limit_in  = speed_limit_ff;
      pos_in          = pos_ff;
      speed_in        = speed_ff;
      dt_in           = dt_ff;
      tgt_in          = tgt_ff;
      vel_neg_in      = vel_neg_ff;
      vel_pos_in      = vel_pos_ff;
      diff_in         = diff_ff;
      prod_in         = prod_ff;
      d40_in          = d40_ff;
      lo_m_in         = lo_m_ff;
      le9_in          = le9_ff;
      le18_in         = le18_ff;
      ge22_in         = ge22_ff;
      ge31_in         = ge31_ff;
      spd_in          = spd_ff;
      mul_req.a       = '0;
      mul_req.b       = '0;

      // Register writes
      if (cfg_wr) begin
         case (cfg_idx)
            REG_WINDOW_WIDTH: window_width_in = csr_pwdata[11:0];
            REG_LEVEL_LEFT:   level_left_in   = csr_pwdata[20:0];
            REG_LEVEL_WIDTH:  level_width_in  = csr_pwdata[20:0];
            REG_ACCEL_RATE:   accel_rate_in   = csr_pwdata[15:0];
            REG_SPEED_LIMIT:  speed_limit_in  = csr_pwdata[15:0];
            default:          ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            // Latch the frame and the target offset
            if (req_xfer) begin
               dt_in      = req_frame_time;
               tgt_in     = req_target_left;
               vel_neg_in = req_target_velocity[15];
               vel_pos_in = !req_target_velocity[15] && (req_target_velocity != 16'sd0);
               diff_in    = {req_target_left[31], req_target_left} - pos_x;
               state_in   = ST_PROD;
            end
         end
         ST_PROD: begin
            // accel * dt
            mul_req.a = {18'd0, accel_rate_ff};
            mul_req.b = {1'b0, dt_ff};
            state_in  = ST_D40;
         end
         ST_D40: begin
            // 40 * offset
            prod_in   = mul_p[31:0];
            mul_req.a = {diff_ff[32], diff_ff};
            mul_req.b = 17'sd40;
            state_in  = ST_MARGIN;
         end
         ST_MARGIN: begin
            // W * 1024 / 5 by reciprocal
            d40_in    = mul_p[38:0];
            mul_req.a = FIFTH_RECIP;
            mul_req.b = {5'd0, window_width_ff};
            state_in  = ST_ZONE;
         end
         ST_ZONE: begin
            // Sort the offset into zones
            lo_m_in  = mul_p[FIFTH_SHIFT+19:FIFTH_SHIFT];
            le9_in   = (d40_ff <= t9);
            le18_in  = (d40_ff <= t18);
            ge22_in  = (d40_ff >= t22);
            ge31_in  = (d40_ff >= t31);
            state_in = ST_SPEED1;
         end
         ST_SPEED1: begin
            spd_in   = spd_cur + add1;
            state_in = ST_SPEED2;
         end
         ST_SPEED2: begin
            // Bleed speed that runs against the target velocity: positive speed above t18, negative speed below t22
            if (!le18_ff && !vel_pos_ff && (spd_ff > 26'sd0)) begin
               spd_in = spd_ff - half_s;
            end else if (!ge22_ff && !vel_neg_ff && (spd_ff < 26'sd0)) begin
               spd_in = spd_ff + half_s;
            end
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            if (spd_ff < -lim_s) begin
               speed_in = 24'(-lim_s);
            end else if (spd_ff > lim_s) begin
               speed_in = 24'(lim_s);
            end else begin
               speed_in = spd_ff[23:0];
            end
            state_in = ST_STEP;
         end
         ST_STEP: begin
            // speed * dt
            mul_req.a = {{10{speed_ff[23]}}, speed_ff};
            mul_req.b = {1'b0, dt_ff};
            state_in  = ST_INTEG;
         end
         ST_INTEG: begin
            pos_in   = sat32(pos_x + {{8{inc[24]}}, inc});
            state_in = ST_FOLLOW;
         end
         ST_FOLLOW: begin
            if (pos_x < lo33) begin
               pos_in = sat32(lo33);
            end else if (pos_x > hi33) begin
               pos_in = sat32(hi33);
            end
            state_in = ST_LEVEL;
         end
         ST_LEVEL: begin
            // Apply level bounds and hand the result to the output register
            if (slot_free) begin
               if (pos_x < left33) begin
                  pos_in = left33[31:0];
               end else if (end33 > right33) begin
                  pos_in = back33[31:0];
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = pos_in;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         window_width_ff <= WINDOW_WIDTH_RESET;
         level_left_ff   <= LEVEL_LEFT_RESET;
         level_width_ff  <= LEVEL_WIDTH_RESET;
         accel_rate_ff   <= ACCEL_RATE_RESET;
         speed_limit_ff  <= SPEED_LIMIT_RESET;
         pos_ff          <= POS_RESET;
         speed_ff        <= 24'sd0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         window_width_ff <= window_width_in;
         level_left_ff   <= level_left_in;
         level_width_ff  <= level_width_in;
         accel_rate_ff   <= accel_rate_in;
         speed_limit_ff  <= speed_limit_in;
         pos_ff          <= pos_in;
         speed_ff        <= speed_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      dt_ff       <= dt_in;
      tgt_ff      <= tgt_in;
      vel_neg_ff  <= vel_neg_in;
      vel_pos_ff  <= vel_pos_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      d40_ff      <= d40_in;
      lo_m_ff     <= lo_m_in;
      le9_ff      <= le9_in;
      le18_ff     <= le18_in;
      ge22_ff     <= ge22_in;
      ge31_ff     <= ge31_in;
      spd_ff      <= spd_in;
   end

   // Speed stays inside the limit after the clamp step
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLAMP) |=>
         ((speed_ff <= $past(lim_s)) && (speed_ff >= -$past(lim_s))))
      else $error("scroll speed outside limit after clamp");

   // A result appears only out of the last step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_LEVEL))
      else $error("result valid raised outside final step");

   // A held result stalls the final step
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_LEVEL) && rsp_valid_ff && !rsp_tready) |=> (state_ff == ST_LEVEL))
      else $error("final step advanced over a held result");

   // A transfer starts the multiply sequence
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == ST_PROD))
      else $error("sequencer did not start after transfer");

   // Reset leaves the sequencer idle with no result
   assert property (@(posedge clock)
      reset |=> ((state_ff == ST_IDLE) && !rsp_valid_ff))
      else $error("sequencer not idle after reset");

endmodule
